### design/sdta_pkg.sv
package sdta_pkg;

	// character codes
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	// digit buffer geometry: a 32-bit magnitude has at most ten decimal digits
	localparam int MAX_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int ND_W       = 4;

	// divide by ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for any 32-bit x
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// one classified number waiting in the queue
	typedef struct packed {
		logic        neg;
		logic [31:0] mag;
	} item_t;

	// converted digits, least significant digit in entry 0
	typedef struct packed {
		logic                                neg;
		logic [ND_W-1:0]                     nd;
		logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;
	} batch_t;

endpackage

### design/sdta_front.sv
module sdta_front
	import sdta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] value,
	output logic        busy,
	input  logic        q_full,
	output logic        q_push,
	output item_t       q_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	// stall only while a classified beat waits on a full queue
	assign busy   = valid_s1 && q_full;
	assign accept = start && !busy;
	assign q_push = valid_s1 && !q_full;
	assign q_item = item_s1;

	// hold the stage valid until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// split sign and unsigned magnitude; the most negative value maps to 2^31
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.neg <= value[31];
			item_s1.mag <= value[31] ? (32'd0 - value) : value;
		end
	end

endmodule

### design/sdta_fifo.sv
module sdta_fifo
	import sdta_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output item_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store the incoming beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

### design/sdta_conv.sv
module sdta_conv
	import sdta_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	input  item_t  q_head,
	output logic   q_pop,
	output logic   batch_valid,
	output batch_t batch,
	input  logic   batch_ready
);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_HOLD = 3'b100
	} conv_state_t;

	conv_state_t                         state_q;
	logic                                neg_q;
	logic [31:0]                         mag_q;
	logic [ND_W-1:0]                     nd_q;
	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_q;

	logic [63:0] prod;
	logic [31:0] quo;
	logic [31:0] times10;
	logic [31:0] rem;

	// one division by ten per cycle through the reciprocal multiplier
	assign prod    = {32'd0, mag_q} * {32'd0, RECIP_TEN};
	assign quo     = {{RECIP_SHIFT - 32{1'b0}}, prod[63:RECIP_SHIFT]};
	assign times10 = (quo << 3) + (quo << 1);
	assign rem     = mag_q - times10;

	assign q_pop        = (state_q == C_IDLE) && q_valid;
	assign batch_valid  = (state_q == C_HOLD);
	assign batch.neg    = neg_q;
	assign batch.nd     = nd_q;
	assign batch.digits = digits_q;

	// sequence: load, peel digits, hold until the emitter takes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (q_valid) begin
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					if (quo == 32'd0 || nd_q == ND_W'(MAX_DIGITS - 1)) begin
						state_q <= C_HOLD;
					end
				end
				C_HOLD: begin
					if (batch_ready) begin
						state_q <= C_IDLE;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	// datapath: magnitude, digit count and digit buffer
	always_ff @(posedge clk) begin
		if (q_pop) begin
			neg_q <= q_head.neg;
			mag_q <= q_head.mag;
			nd_q  <= '0;
		end else if (state_q == C_RUN) begin
			digits_q[nd_q] <= rem[DIGIT_W-1:0];
			nd_q           <= nd_q + 1'b1;
			mag_q          <= quo;
		end
	end

endmodule

### design/sdta_emit.sv
module sdta_emit
	import sdta_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       batch_valid,
	input  batch_t     batch,
	output logic       batch_ready,
	output logic       strobe,
	output logic [7:0] character,
	output logic       last
);

	logic                                active_q;
	logic                                sign_q;
	logic [ND_W-1:0]                     idx_q;
	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_q;
	logic                                strobe_q;
	logic [7:0]                          character_q;
	logic                                last_q;

	logic finishing;
	logic take;

	// the final digit is registered this cycle, so the next batch may load behind it
	assign finishing   = active_q && !sign_q && (idx_q == '0);
	assign batch_ready = !active_q || finishing;
	assign take        = batch_valid && batch_ready;

	assign strobe    = strobe_q;
	assign character = character_q;
	assign last      = last_q;

	// walk sign first, then digits from most significant down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			sign_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (take) begin
				active_q <= 1'b1;
				sign_q   <= batch.neg;
			end else if (finishing) begin
				active_q <= 1'b0;
			end else if (active_q && sign_q) begin
				sign_q <= 1'b0;
			end
		end
	end

	// digit pointer and buffer copy
	always_ff @(posedge clk) begin
		if (take) begin
			idx_q    <= batch.nd - 1'b1;
			digits_q <= batch.digits;
		end else if (active_q && !sign_q) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	// register the outgoing beat
	always_ff @(posedge clk) begin
		if (active_q) begin
			character_q <= sign_q ? ASCII_MINUS : (ASCII_ZERO + {4'd0, digits_q[idx_q]});
			last_q      <= !sign_q && (idx_q == '0);
		end
	end

	// characters of one number leave in consecutive cycles
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside a number's text");

	// only digits or the sign ever leave
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((character >= ASCII_ZERO && character <= ASCII_ZERO + 8'd9) ||
			character == ASCII_MINUS))
		else $error("illegal character emitted");

	// the sign is never the final character
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && character == ASCII_MINUS |-> !last)
		else $error("sign flagged as last");

endmodule

### design/signed_int_to_decimal_ascii_top.sv
// Signed 32-bit integer to decimal ASCII. Pulse start with value while busy is low;
// the text then leaves most significant character first, one character per cycle
// with strobe high, and last marks the final character. The receiver cannot stall,
// so each character is valid for exactly one cycle. A small queue holds accepted
// numbers; busy rises only when that queue is full. Each number passes through
// the classifier, then the divide-by-ten loop (one reciprocal multiply per digit,
// nd = 1 to 10 digits), then its 1 to 11 characters leave back to back. Conversion
// of the next number overlaps emission of the current one.
module signed_int_to_decimal_ascii_top
	import sdta_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic signed [31:0] value,
	output logic        busy,
	output logic        strobe,
	output logic [7:0]  character,
	output logic        last
);

	logic   q_full;
	logic   q_push;
	item_t  q_item;
	logic   q_pop;
	logic   q_valid;
	item_t  q_head;
	logic   batch_valid;
	logic   batch_ready;
	batch_t batch;

	sdta_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (value),
		.busy   (busy),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_item)
	);

	sdta_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_item),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.head    (q_head)
	);

	sdta_conv u_conv (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.batch_valid (batch_valid),
		.batch       (batch),
		.batch_ready (batch_ready)
	);

	sdta_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.batch_valid (batch_valid),
		.batch       (batch),
		.batch_ready (batch_ready),
		.strobe      (strobe),
		.character   (character),
		.last        (last)
	);

endmodule
